// ----- design/lws_pkg.sv -----
//------------------------------------------------------------------------------
// lws_pkg - shared types and codes for the latency statistics block
// Commands, status codes, window codes, channel codes and sequencer states.
//------------------------------------------------------------------------------
`default_nettype none
package lws_pkg;

    localparam logic [2:0] CMD_SET_WINDOW = 3'd0;
    localparam logic [2:0] CMD_DRIVE_HIGH = 3'd1;
    localparam logic [2:0] CMD_DRIVE_LOW  = 3'd2;
    localparam logic [2:0] CMD_GPIO_EDGE  = 3'd3;
    localparam logic [2:0] CMD_TIMER_IRQ  = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;
    localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
    localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

    localparam logic [2:0] ST_RECORDED    = 3'd0;
    localparam logic [2:0] ST_GPIO_WINDOW = 3'd1;
    localparam logic [2:0] ST_NO_FLAG     = 3'd2;
    localparam logic [2:0] ST_TIMER_OUT   = 3'd3;
    localparam logic [2:0] ST_NO_SAMPLE   = 3'd4;

    localparam logic [1:0] WIN_NONE     = 2'd0;
    localparam logic [1:0] WIN_GPIO     = 2'd1;
    localparam logic [1:0] WIN_TIMER    = 2'd2;
    localparam logic [1:0] WIN_RESERVED = 2'd3;

    localparam logic [1:0] CH_SOURCE = 2'd0;
    localparam logic [1:0] CH_GPIO   = 2'd1;
    localparam logic [1:0] CH_TIMER  = 2'd2;

    localparam int DIV_STEPS = 49;
    localparam int MUL_STEPS = 49;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MEAN,
        S_MUL,
        S_ACC,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// ----- design/latency_welford_stats.sv -----
// Items that take no sample or are rejected have their result registered on
//   acceptance; a recorded sample runs a restoring divide at one quotient bit per
//   cycle, mean update, shift-add multiply at one bit per cycle, m2 add, output.
// One item at a time; the next item can be taken the cycle after the previous
//   result is accepted.
// Reset: aresetn synchronous, active low; all statistics clear to zero.
//------------------------------------------------------------------------------
// latency_welford_stats - three-channel running latency statistics
// Bit-serial Welford update of count, min, max, mean and m2 per channel.
//------------------------------------------------------------------------------
`default_nettype none
module latency_welford_stats (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command[2:0], window[4:3], time_before[36:5], time_after[68:37], compare_flag[69]
    input  wire logic [71:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[2:0], channel[4:3], sample[36:5], count[68:37], mean[116:69],
    // sum_sq_dev[180:117], min_sample[212:181], max_sample[244:213],
    // reject_count[276:245]
    output logic [279:0]      m_tdata
);
    import lws_pkg::*;

    localparam logic [279:0] NO_SAMPLE_WORD = {277'd0, ST_NO_SAMPLE};

    state_t state_reg, state_next;

    logic [1:0]  win_reg;
    logic [31:0] emit_reg;
    logic        level_reg;
    logic [31:0] cnt_reg  [3];
    logic [47:0] mean_reg [3];
    logic [63:0] m2_reg   [3];
    logic [31:0] min_reg  [3];
    logic [31:0] max_reg  [3];
    logic [31:0] rej_reg  [3];

    logic [1:0]  ch_reg;
    logic [31:0] smp_reg;
    logic [48:0] dmag_reg;     // |delta|
    logic        dneg_reg;
    logic [48:0] quo_reg;      // quotient shift register
    logic [32:0] rem_reg;      // partial remainder
    logic [31:0] n_reg;
    logic [5:0]  step_reg;
    logic [48:0] mplr_reg;     // multiplier, shifts right
    logic [97:0] mcand_reg;    // multiplicand, shifts left
    logic [97:0] prod_reg;

    logic        out_valid_reg;
    logic [279:0] out_reg;

    logic [2:0]  cmd;
    logic [1:0]  win_in;
    logic [31:0] tb, ta;
    logic        flag;

    assign cmd    = s_tdata[2:0];
    assign win_in = s_tdata[4:3];
    assign tb     = s_tdata[36:5];
    assign ta     = s_tdata[68:37];
    assign flag   = s_tdata[69];

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    logic accept;
    assign accept = s_tvalid && s_tready;

    // per-item combinational helpers
    logic [48:0] s_fix;
    logic [48:0] mean_ext;
    logic [48:0] delta;
    logic [48:0] delta_mag;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic [48:0] new_mean;
    logic [64:0] m2_sum;
    logic [31:0] cnt_new;

    // delta is taken against the stored mean: the old one before S_MUL,
    // the updated one from S_MUL on
    assign s_fix    = {smp_reg[31], smp_reg, 16'd0};
    assign mean_ext = {mean_reg[ch_reg][47], mean_reg[ch_reg]};
    assign delta    = s_fix - mean_ext;
    assign delta_mag = delta[48] ? (~delta + 49'd1) : delta;
    assign rem_shift = {rem_reg[31:0], dmag_reg[48]};
    assign rem_sub   = rem_shift - {1'b0, n_reg};
    assign new_mean  = mean_ext + (dneg_reg ? (~quo_reg + 49'd1) : quo_reg);
    assign m2_sum    = {1'b0, m2_reg[ch_reg]} + {1'b0, prod_reg[87:24]};
    assign cnt_new   = (cnt_reg[ch_reg] == 32'hFFFF_FFFF) ? cnt_reg[ch_reg]
                                                          : cnt_reg[ch_reg] + 32'd1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept && (cmd == CMD_DRIVE_HIGH ||
                                   (cmd == CMD_GPIO_EDGE && win_reg == WIN_GPIO) ||
                                   (cmd == CMD_TIMER_IRQ && flag && win_reg == WIN_TIMER)))
                        state_next = S_DIV;
            S_DIV:  if (step_reg == 6'(DIV_STEPS)) state_next = S_MEAN;
            S_MEAN: state_next = S_MUL;
            S_MUL:  if (step_reg == 6'(MUL_STEPS)) state_next = S_ACC;
            S_ACC:  state_next = S_OUT;
            S_OUT:  if (!out_valid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    function automatic logic [31:0] bumped(input logic [31:0] v);
        bumped = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            win_reg       <= WIN_NONE;
            emit_reg      <= '0;
            level_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                cnt_reg[i] <= '0; mean_reg[i] <= '0; m2_reg[i] <= '0;
                min_reg[i] <= '0; max_reg[i] <= '0; rej_reg[i] <= '0;
            end
            step_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (accept) begin
                    step_reg <= '0;
                    rem_reg  <= '0;
                    case (cmd)
                        CMD_SET_WINDOW: begin
                            win_reg <= (win_in == WIN_RESERVED) ? WIN_NONE : win_in;
                            out_reg <= NO_SAMPLE_WORD;
                            out_valid_reg <= 1'b1;
                        end
                        CMD_DRIVE_HIGH: begin
                            emit_reg  <= tb;
                            level_reg <= 1'b1;
                            ch_reg    <= CH_SOURCE;
                            smp_reg   <= ta - tb;
                        end
                        CMD_DRIVE_LOW: begin
                            level_reg <= 1'b0;
                            out_reg <= NO_SAMPLE_WORD;
                            out_valid_reg <= 1'b1;
                        end
                        CMD_GPIO_EDGE: begin
                            ch_reg  <= CH_GPIO;
                            smp_reg <= tb - emit_reg;
                            if (win_reg != WIN_GPIO) begin
                                rej_reg[0] <= bumped(rej_reg[0]);
                                out_reg <= {3'd0, bumped(rej_reg[0]), max_reg[1],
                                            min_reg[1], m2_reg[1], mean_reg[1],
                                            cnt_reg[1], 32'd0, CH_GPIO, ST_GPIO_WINDOW};
                                out_valid_reg <= 1'b1;
                            end
                        end
                        CMD_TIMER_IRQ: begin
                            ch_reg  <= CH_TIMER;
                            smp_reg <= tb - emit_reg;
                            if (!flag) begin
                                rej_reg[1] <= bumped(rej_reg[1]);
                                out_reg <= {3'd0, bumped(rej_reg[1]), max_reg[2],
                                            min_reg[2], m2_reg[2], mean_reg[2],
                                            cnt_reg[2], 32'd0, CH_TIMER, ST_NO_FLAG};
                                out_valid_reg <= 1'b1;
                            end else if (win_reg != WIN_TIMER) begin
                                rej_reg[2] <= bumped(rej_reg[2]);
                                out_reg <= {3'd0, bumped(rej_reg[2]), max_reg[2],
                                            min_reg[2], m2_reg[2], mean_reg[2],
                                            cnt_reg[2], 32'd0, CH_TIMER, ST_TIMER_OUT};
                                out_valid_reg <= 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            win_reg   <= WIN_NONE;
                            emit_reg  <= '0;
                            level_reg <= 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                cnt_reg[i] <= '0; mean_reg[i] <= '0; m2_reg[i] <= '0;
                                min_reg[i] <= '0; max_reg[i] <= '0; rej_reg[i] <= '0;
                            end
                            out_reg <= NO_SAMPLE_WORD;
                            out_valid_reg <= 1'b1;
                        end
                        default: begin
                            out_reg <= NO_SAMPLE_WORD;
                            out_valid_reg <= 1'b1;
                        end
                    endcase
                end
                S_DIV: begin
                    if (step_reg == 6'd0) begin
                        // update count, min, max; latch |delta| and divisor
                        cnt_reg[ch_reg] <= cnt_new;
                        n_reg <= cnt_new;
                        if (cnt_new == 32'd1) begin
                            min_reg[ch_reg] <= smp_reg;
                            max_reg[ch_reg] <= smp_reg;
                        end else begin
                            if ($signed(smp_reg) < $signed(min_reg[ch_reg]))
                                min_reg[ch_reg] <= smp_reg;
                            if ($signed(smp_reg) > $signed(max_reg[ch_reg]))
                                max_reg[ch_reg] <= smp_reg;
                        end
                        dneg_reg <= delta[48];
                        dmag_reg <= delta_mag;
                        step_reg <= 6'd1;
                    end else begin
                        // one restoring divide step per cycle
                        if (!rem_sub[32]) begin
                            rem_reg <= rem_sub;
                            quo_reg <= {quo_reg[47:0], 1'b1};
                        end else begin
                            rem_reg <= rem_shift;
                            quo_reg <= {quo_reg[47:0], 1'b0};
                        end
                        dmag_reg <= {dmag_reg[47:0], 1'b0};
                        step_reg <= step_reg + 6'd1;
                    end
                end
                S_MEAN: begin
                    // mean still holds the old value here, so delta is the first delta
                    mean_reg[ch_reg] <= new_mean[47:0];
                    mplr_reg <= delta_mag;
                    step_reg <= '0;
                    prod_reg <= '0;
                end
                S_MUL: begin
                    if (step_reg == 6'd0) begin
                        // delta against the updated mean
                        mcand_reg <= {49'd0, delta_mag};
                        step_reg  <= 6'd1;
                    end else begin
                        if (mplr_reg[0]) prod_reg <= prod_reg + mcand_reg;
                        mplr_reg  <= {1'b0, mplr_reg[48:1]};
                        mcand_reg <= {mcand_reg[96:0], 1'b0};
                        step_reg  <= step_reg + 6'd1;
                    end
                end
                S_ACC: begin
                    if (prod_reg[97:88] != 10'd0 || m2_sum[64])
                        m2_reg[ch_reg] <= 64'hFFFF_FFFF_FFFF_FFFF;
                    else
                        m2_reg[ch_reg] <= m2_sum[63:0];
                end
                S_OUT: if (!out_valid_reg) begin
                    out_reg <= {3'd0, 32'd0, max_reg[ch_reg], min_reg[ch_reg],
                                m2_reg[ch_reg], mean_reg[ch_reg], cnt_reg[ch_reg],
                                smp_reg, ch_reg, ST_RECORDED};
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    property p_ready_idle;
        @(posedge aclk) disable iff (!aresetn) s_tready |-> !m_tvalid;
    endproperty
    assert property (p_ready_idle) else $error("accepting while result pending");

    property p_rec_count;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[2:0] == ST_RECORDED) |-> m_tdata[68:37] != 32'd0;
    endproperty
    assert property (p_rec_count) else $error("recorded item with zero count");

    property p_busy;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == S_DIV) |=> !s_tready;
    endproperty
    assert property (p_busy) else $error("ready during sample update");

    property p_source_level;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[2:0] == ST_RECORDED && m_tdata[4:3] == CH_SOURCE)
                |-> level_reg;
    endproperty
    assert property (p_source_level) else $error("source sample with output low");

endmodule
`default_nettype wire

// ----- dv/tb_latency_welford_stats.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_latency_welford_stats - self-checking bench for the latency statistics block
// Drives windowed latency events over the input stream, predicts every result
// with an independent Welford model and checks each result field by field.
//------------------------------------------------------------------------------
module tb_latency_welford_stats;
    import lws_pkg::*;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [31:0] reject_count;
        logic [31:0] max_sample;
        logic [31:0] min_sample;
        logic [63:0] sum_sq_dev;
        logic [47:0] mean;
        logic [31:0] count;
        logic [31:0] sample;
        logic [1:0]  channel;
        logic [2:0]  status;
    } stats_rec_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [279:0] m_tdata;

    latency_welford_stats uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [1:0]         win_q;
    logic [31:0]        emit_q;
    logic [31:0]        cnt_q  [3];
    logic signed [47:0] mean_q [3];
    logic [63:0]        m2_q   [3];
    logic signed [31:0] min_q  [3];
    logic signed [31:0] max_q  [3];
    logic [31:0]        rej_q  [3];

    stats_rec_t expected_results[$];
    int  errors;
    bit  sink_stall_en;
    int  sink_hold;
    int  sink_gap;
    int  idle_cycles;
    bit  timed_out;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic clear_model();
        win_q  = WIN_NONE;
        emit_q = '0;
        for (int i = 0; i < 3; i++) begin
            cnt_q[i] = '0; mean_q[i] = '0; m2_q[i] = '0;
            min_q[i] = '0; max_q[i] = '0; rej_q[i] = '0;
        end
    endtask

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic model_sample(int ch, logic signed [31:0] s);
        logic signed [63:0]  scaled, dlt, dlt2, q;
        logic [63:0]         ad, ad2, uq, inc;
        logic [127:0]        prod;
        logic [64:0]         sum;
        cnt_q[ch] = sat_inc(cnt_q[ch]);
        if (cnt_q[ch] == 32'd1) begin
            min_q[ch] = s;
            max_q[ch] = s;
        end else begin
            if (s < min_q[ch]) min_q[ch] = s;
            if (s > max_q[ch]) max_q[ch] = s;
        end
        scaled = 64'(s) <<< 16;
        dlt = scaled - 64'(mean_q[ch]);
        ad  = dlt[63] ? 64'(-dlt) : 64'(dlt);
        uq  = ad / {32'd0, cnt_q[ch]};
        q   = dlt[63] ? -$signed(uq) : $signed(uq);
        mean_q[ch] = 48'(64'(mean_q[ch]) + q);
        dlt2 = scaled - 64'(mean_q[ch]);
        ad2  = dlt2[63] ? 64'(-dlt2) : 64'(dlt2);
        prod = {64'd0, ad} * {64'd0, ad2};
        if (prod[127:88] != '0) begin
            m2_q[ch] = '1;
        end else begin
            inc = prod[87:24];
            sum = {1'b0, m2_q[ch]} + {1'b0, inc};
            m2_q[ch] = sum[64] ? '1 : sum[63:0];
        end
    endtask

    function automatic stats_rec_t report(logic [2:0] st, int ch, logic [31:0] s,
                                          logic [31:0] rej);
        stats_rec_t r;
        r.status = st; r.channel = 2'(ch); r.sample = s;
        r.count = cnt_q[ch]; r.mean = mean_q[ch]; r.sum_sq_dev = m2_q[ch];
        r.min_sample = min_q[ch]; r.max_sample = max_q[ch]; r.reject_count = rej;
        return r;
    endfunction

    task automatic predict_event(logic [2:0] cmd, logic [1:0] win, logic [31:0] tb,
                                 logic [31:0] ta, logic flag);
        stats_rec_t r;
        logic [31:0] s;
        r = '0;
        r.status = ST_NO_SAMPLE;
        case (cmd)
            CMD_SET_WINDOW: win_q = (win == WIN_RESERVED) ? WIN_NONE : win;
            CMD_DRIVE_HIGH: begin
                s = ta - tb;
                emit_q = tb;
                model_sample(CH_SOURCE, s);
                r = report(ST_RECORDED, CH_SOURCE, s, '0);
            end
            CMD_GPIO_EDGE: begin
                if (win_q != WIN_GPIO) begin
                    rej_q[0] = sat_inc(rej_q[0]);
                    r = report(ST_GPIO_WINDOW, CH_GPIO, '0, rej_q[0]);
                end else begin
                    s = tb - emit_q;
                    model_sample(CH_GPIO, s);
                    r = report(ST_RECORDED, CH_GPIO, s, '0);
                end
            end
            CMD_TIMER_IRQ: begin
                if (!flag) begin
                    rej_q[1] = sat_inc(rej_q[1]);
                    r = report(ST_NO_FLAG, CH_TIMER, '0, rej_q[1]);
                end else if (win_q != WIN_TIMER) begin
                    rej_q[2] = sat_inc(rej_q[2]);
                    r = report(ST_TIMER_OUT, CH_TIMER, '0, rej_q[2]);
                end else begin
                    s = tb - emit_q;
                    model_sample(CH_TIMER, s);
                    r = report(ST_RECORDED, CH_TIMER, s, '0);
                end
            end
            CMD_CLEAR: clear_model();
            default: ;
        endcase
        expected_results.push_back(r);
    endtask

    // send one item; idle bursts optional
    task automatic send_event(logic [2:0] cmd, logic [1:0] win, logic [31:0] tb,
                              logic [31:0] ta, logic flag, bit gaps = 1);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, flag, ta, tb, win, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_event(cmd, win, tb, ta, flag);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_event(CMD_TIMER_IRQ, WIN_NONE, 32'd5, 32'd0, 1'b0);
        send_event(CMD_TIMER_IRQ, WIN_NONE, 32'd5, 32'd0, 1'b1);
        send_event(CMD_GPIO_EDGE, WIN_NONE, 32'd5, 32'd0, 1'b0);
        send_event(CMD_DRIVE_HIGH, WIN_NONE, 32'd0, 32'd0, 1'b0);
        send_event(CMD_DRIVE_HIGH, WIN_NONE, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b1);
        send_event(CMD_DRIVE_HIGH, WIN_NONE, 32'd0, 32'h8000_0000, 1'b0);
        send_event(CMD_SET_WINDOW, WIN_GPIO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(CMD_GPIO_EDGE, WIN_NONE, 32'h7FFF_FFFE, 32'd0, 1'b0);
        send_event(CMD_GPIO_EDGE, WIN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(CMD_TIMER_IRQ, WIN_NONE, 32'd9, 32'd0, 1'b1);
        send_event(CMD_SET_WINDOW, WIN_RESERVED, 32'd0, 32'd0, 1'b0);
        send_event(CMD_GPIO_EDGE, WIN_NONE, 32'd9, 32'd0, 1'b0);
        send_event(CMD_SET_WINDOW, WIN_TIMER, 32'd0, 32'd0, 1'b0);
        send_event(CMD_DRIVE_LOW, WIN_NONE, 32'd1, 32'd2, 1'b1);
        send_event(CMD_TIMER_IRQ, WIN_NONE, 32'h8000_0000, 32'd0, 1'b1);
        send_event(CMD_TIMER_IRQ, WIN_NONE, 32'h0000_0001, 32'd0, 1'b1);
        send_event(CMD_RESERVED_6, WIN_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(CMD_RESERVED_7, WIN_NONE, 32'd0, 32'd0, 1'b0);
        send_event(CMD_CLEAR, WIN_NONE, 32'd0, 32'd0, 1'b0);
        send_event(CMD_TIMER_IRQ, WIN_NONE, 32'd3, 32'd0, 1'b1);
        send_event(CMD_DRIVE_HIGH, WIN_NONE, 32'd100, 32'd90, 1'b0);
        drain();
    endtask

    // mostly well-formed measurement cycles with random timing
    task automatic test_random_cycles(int n, bit gaps);
        logic [31:0] t;
        logic [1:0]  w;
        for (int i = 0; i < n; i++) begin
            t = $urandom();
            case ($urandom_range(0, 9))
                0: send_event(3'($urandom_range(0, 7)), 2'($urandom()), $urandom(),
                              $urandom(), 1'($urandom()), gaps);
                1: send_event(CMD_TIMER_IRQ, WIN_NONE, $urandom(), $urandom(),
                              1'($urandom()), gaps);
                default: begin
                    w = $urandom_range(0, 1) ? WIN_GPIO : WIN_TIMER;
                    send_event(CMD_SET_WINDOW, w, $urandom(), $urandom(), 1'($urandom()),
                               gaps);
                    send_event(CMD_DRIVE_HIGH, WIN_NONE, t,
                               ($urandom_range(0, 7) == 0) ? $urandom()
                                   : t + $urandom_range(0, 400), 1'($urandom()), gaps);
                    send_event(w == WIN_GPIO ? CMD_GPIO_EDGE : CMD_TIMER_IRQ, WIN_NONE,
                               ($urandom_range(0, 7) == 0) ? $urandom()
                                   : t + $urandom_range(0, 5000),
                               $urandom(), ($urandom_range(0, 9) != 0), gaps);
                    send_event(CMD_DRIVE_LOW, WIN_NONE, $urandom(), $urandom(),
                               1'($urandom()), gaps);
                end
            endcase
        end
    endtask

    // stall the receiver for a long stretch while items keep coming
    task automatic test_backpressure();
        sink_hold = 300;
        for (int i = 0; i < 12; i++)
            send_event(CMD_TIMER_IRQ, WIN_NONE, $urandom(), $urandom(), 1'b0, 0);
        drain();
    endtask

    // receiver side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (sink_stall_en && m_tready && $urandom_range(0, 4) == 0) begin
            sink_gap <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        stats_rec_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = stats_rec_t'(m_tdata[276:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp = expected_results.pop_front();
                if (got.status !== exp.status || got.channel !== exp.channel ||
                    got.sample !== exp.sample || got.count !== exp.count ||
                    got.mean !== exp.mean || got.sum_sq_dev !== exp.sum_sq_dev ||
                    got.min_sample !== exp.min_sample ||
                    got.max_sample !== exp.max_sample ||
                    got.reject_count !== exp.reject_count) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp, got);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000 && !timed_out) begin
            timed_out = 1'b1;
            $display("[latency_welford_stats] ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0; timed_out = 0; idle_cycles = 0;
        sink_stall_en = 1'b1; sink_hold = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        clear_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_cycles(70, 1);
        test_backpressure();
        sink_stall_en = 1'b0;
        test_random_cycles(30, 0);
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("[latency_welford_stats] OK");
        else
            $display("[latency_welford_stats] ERROR");
        $finish;
    end

endmodule
